[rtl/core/lsa_pkg.sv]
// shared types and constants for the laplacian saliency selector
package lsa_pkg;

   localparam int NumImages       = 4;
   localparam int PixBits         = 8;
   localparam int MagBits         = PixBits + 3;
   localparam int RowBits         = 12;
   localparam int WidthBits       = 11;
   localparam int HeightBits      = 13;
   localparam int CsrDataBits     = 13;
   localparam int ImgBits         = $clog2(NumImages);
   localparam int PackBits        = NumImages * PixBits;
   localparam int DefaultMaxWidth = 1024;
   localparam int MaxHeight       = 4096;

   localparam logic [WidthBits-1:0]  FrameWidthReset  = WidthBits'(640);
   localparam logic [HeightBits-1:0] FrameHeightReset = HeightBits'(480);

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } lsa_csr_type;

   typedef enum logic [1:0] {
      STEP_UP_MID = 2'd0,
      STEP_DN_MID = 2'd1,
      STEP_UP_END = 2'd2,
      STEP_DN_END = 2'd3
   } lsa_step_type;

   // 3x3 neighbourhood of one frame, raster order, entry 4 is the centre
   typedef logic [8:0][PixBits-1:0] lsa_win_type;

   typedef logic [NumImages-1:0][MagBits-1:0] lsa_mag_array_type;

   typedef struct packed {
      logic [RowBits-1:0] row;
      logic               last_in_run;
      logic               frame_done;
   } lsa_tag_type;

endpackage

[rtl/core/laplacian_saliency_argmax.sv]
// Laplacian saliency selector: one item per clock in steady state, unless the receiver stalls or
// an earlier item has results pending. An item carries the co-located gray pixel of every frame;
// each frame runs through its own laplacian lane and a merge stage picks the frame with the
// largest magnitude. Results come out one per cycle, unless stalled, through a single merge and
// output register, so an item past the first column of the last row yields two results, the last
// item of each row below the first one extra, and the final item of the frame four. Results
// trail the input by one row and one column. The line store needs no clearing after reset.
// Configuration writes return the raster position to the start of the frame.
module laplacian_saliency_argmax #(
   parameter int MAX_WIDTH = lsa_pkg::DefaultMaxWidth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lsa_pkg::PixBits-1:0]       req_gray_0,
   input  logic [lsa_pkg::PixBits-1:0]       req_gray_1,
   input  logic [lsa_pkg::PixBits-1:0]       req_gray_2,
   input  logic [lsa_pkg::PixBits-1:0]       req_gray_3,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lsa_pkg::ImgBits-1:0]       rsp_best_image,
   output logic [lsa_pkg::MagBits-1:0]       rsp_best_saliency,
   output logic [lsa_pkg::RowBits-1:0]       rsp_out_row,
   output logic [$clog2(MAX_WIDTH)-1:0]      rsp_out_col,
   output logic                              rsp_last_in_run,
   output logic                              rsp_frame_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  lsa_pkg::lsa_csr_type              csr_index,
   input  logic [lsa_pkg::CsrDataBits-1:0]   csr_wdata
);
   import lsa_pkg::*;

   localparam int ColBits = $clog2(MAX_WIDTH);

   // configuration
   logic [WidthBits-1:0]  frame_width_ff;
   logic [HeightBits-1:0] frame_height_ff;
   logic [HeightBits-1:0] wsat;
   logic [HeightBits-1:0] hsat;
   logic [ColBits-1:0]    last_col;
   logic [RowBits-1:0]    last_row;
   logic                  csr_fire;

   // raster position
   logic [RowBits-1:0] row_ff;
   logic [ColBits-1:0] col_ff;
   logic               req_fire;
   logic               at_last_col;
   logic               at_last_row;
   logic [PackBits-1:0] pix_in;
   logic [PackBits-1:0] rd_bank0;
   logic [PackBits-1:0] rd_bank1;

   // read stage
   logic                b_valid_ff;
   logic [PackBits-1:0] b_pix_ff;
   logic [RowBits-1:0]  b_row_ff;
   logic [ColBits-1:0]  b_col_ff;
   logic                b_last_row_ff;
   logic                b_last_col_ff;
   logic                b_adv;
   logic                b_free;
   logic [PackBits-1:0] b_rd_older;
   logic [PackBits-1:0] b_rd_prev;
   logic                b_emit;

   // window stage
   logic [2:0][2:0][PackBits-1:0] window_ff;
   logic [3:0]          c_mask_ff;
   logic [RowBits-1:0]  c_row_ff;
   logic [ColBits-1:0]  c_col_ff;
   lsa_step_type        step;
   logic [3:0]          step_bit;
   logic [3:0]          mask_next;
   logic                up;
   logic                mid;
   logic                c_emit;
   logic                c_free;
   logic [2:0][2:0][PackBits-1:0] sel;
   logic [2:0][PackBits-1:0]      srow [3];
   lsa_win_type         lane_win [NumImages];
   lsa_mag_array_type   lane_mag;
   lsa_tag_type         c_tag;
   logic [ColBits-1:0]  c_out_col;

   // magnitude stage
   logic                d_valid_ff;
   lsa_mag_array_type   d_mag_ff;
   lsa_tag_type         d_tag_ff;
   logic [ColBits-1:0]  d_col_ff;
   logic                d_free;
   logic                d_adv;

   // output register
   logic                rsp_valid_ff;
   logic [ImgBits-1:0]  rsp_idx_ff;
   logic [MagBits-1:0]  rsp_mag_ff;
   lsa_tag_type         rsp_tag_ff;
   logic [ColBits-1:0]  rsp_col_ff;
   logic                out_free;
   logic [ImgBits-1:0]  merge_idx;
   logic [MagBits-1:0]  merge_mag;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FrameWidthReset;
         frame_height_ff <= FrameHeightReset;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[WidthBits-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata;
            end
            default: begin
               frame_width_ff <= frame_width_ff;
            end
         endcase
      end
   end

   // size saturation
   always_comb begin
      if (frame_width_ff < WidthBits'(2)) begin
         wsat = HeightBits'(2);
      end else if (HeightBits'(frame_width_ff) > HeightBits'(MAX_WIDTH)) begin
         wsat = HeightBits'(MAX_WIDTH);
      end else begin
         wsat = HeightBits'(frame_width_ff);
      end
      if (frame_height_ff < HeightBits'(2)) begin
         hsat = HeightBits'(2);
      end else if (frame_height_ff > HeightBits'(MaxHeight)) begin
         hsat = HeightBits'(MaxHeight);
      end else begin
         hsat = frame_height_ff;
      end
      last_col = ColBits'(wsat - HeightBits'(1));
      last_row = RowBits'(hsat - HeightBits'(1));
   end

   assign req_fire    = req_valid && req_ready;
   assign at_last_col = (col_ff == last_col);
   assign at_last_row = (row_ff == last_row);
   assign pix_in      = {req_gray_3, req_gray_2, req_gray_1, req_gray_0};

   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_fire) begin
         if (at_last_col) begin
            col_ff <= '0;
            row_ff <= at_last_row ? '0 : row_ff + RowBits'(1);
         end else begin
            col_ff <= col_ff + ColBits'(1);
         end
      end
   end

   // line store banks, even and odd rows
   lsa_line_ram #(
      .DEPTH(MAX_WIDTH),
      .WIDTH(PackBits)
   ) u_bank0 (
      .clock  (clock),
      .rd_en  (req_fire),
      .wr_en  (req_fire && !row_ff[0]),
      .addr   (col_ff),
      .wr_data(pix_in),
      .rd_data(rd_bank0)
   );

   lsa_line_ram #(
      .DEPTH(MAX_WIDTH),
      .WIDTH(PackBits)
   ) u_bank1 (
      .clock  (clock),
      .rd_en  (req_fire),
      .wr_en  (req_fire && row_ff[0]),
      .addr   (col_ff),
      .wr_data(pix_in),
      .rd_data(rd_bank1)
   );

   // read stage
   assign b_free    = !b_valid_ff || c_free;
   assign b_adv     = b_valid_ff && c_free;
   assign req_ready = b_free;
   assign b_rd_older = b_row_ff[0] ? rd_bank1 : rd_bank0;
   assign b_rd_prev  = b_row_ff[0] ? rd_bank0 : rd_bank1;
   assign b_emit     = (b_row_ff != '0) && (b_col_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (req_fire) begin
         b_valid_ff <= 1'b1;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_pix_ff      <= pix_in;
         b_row_ff      <= row_ff;
         b_col_ff      <= col_ff;
         b_last_row_ff <= at_last_row;
         b_last_col_ff <= at_last_col;
      end
   end

   // window stage, one result per cycle from the pending mask while the magnitude stage is free
   always_comb begin
      if (c_mask_ff[0]) begin
         step = STEP_UP_MID;
      end else if (c_mask_ff[1]) begin
         step = STEP_DN_MID;
      end else if (c_mask_ff[2]) begin
         step = STEP_UP_END;
      end else begin
         step = STEP_DN_END;
      end
      step_bit  = 4'b0001 << step;
      mask_next = c_mask_ff & ~step_bit;
      up  = (step == STEP_UP_MID) || (step == STEP_UP_END);
      mid = (step == STEP_UP_MID) || (step == STEP_DN_MID);
   end

   assign c_emit = (c_mask_ff != '0) && d_free;
   assign c_free = (c_mask_ff == '0) || ((mask_next == '0) && d_free);

   // reflect-101 row and column selection
   always_comb begin
      srow[0] = up ? ((c_row_ff == RowBits'(1)) ? window_ff[2] : window_ff[0]) : window_ff[1];
      srow[1] = up ? window_ff[1] : window_ff[2];
      srow[2] = up ? window_ff[2] : window_ff[1];
      for (int i = 0; i < 3; i++) begin
         sel[i][0] = mid ? ((c_col_ff == ColBits'(1)) ? srow[i][2] : srow[i][0]) : srow[i][1];
         sel[i][1] = mid ? srow[i][1] : srow[i][2];
         sel[i][2] = mid ? srow[i][2] : srow[i][1];
      end
      for (int k = 0; k < NumImages; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               lane_win[k][i*3+j] = sel[i][j][k*PixBits +: PixBits];
            end
         end
      end
   end

   for (genvar k = 0; k < NumImages; k++) begin : g_lane
      lsa_lane u_lane (
         .win(lane_win[k]),
         .mag(lane_mag[k])
      );
   end

   always_comb begin
      c_tag.row         = up ? c_row_ff - RowBits'(1) : c_row_ff;
      c_tag.last_in_run = (mask_next == '0);
      c_tag.frame_done  = (step == STEP_DN_END);
      c_out_col         = mid ? c_col_ff - ColBits'(1) : c_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_mask_ff <= '0;
      end else if (b_adv) begin
         c_mask_ff <= {b_emit && b_last_row_ff && b_last_col_ff, b_emit && b_last_col_ff,
                       b_emit && b_last_row_ff, b_emit};
      end else if (c_emit) begin
         c_mask_ff <= mask_next;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         for (int i = 0; i < 3; i++) begin
            window_ff[i][0] <= window_ff[i][1];
            window_ff[i][1] <= window_ff[i][2];
         end
         window_ff[0][2] <= b_rd_older;
         window_ff[1][2] <= b_rd_prev;
         window_ff[2][2] <= b_pix_ff;
         c_row_ff        <= b_row_ff;
         c_col_ff        <= b_col_ff;
      end
   end

   // magnitude stage
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign d_free   = !d_valid_ff || out_free;
   assign d_adv    = d_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (c_emit) begin
         d_valid_ff <= 1'b1;
      end else if (out_free) begin
         d_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_emit) begin
         d_mag_ff <= lane_mag;
         d_tag_ff <= c_tag;
         d_col_ff <= c_out_col;
      end
   end

   lsa_merge u_merge (
      .mags    (d_mag_ff),
      .best_idx(merge_idx),
      .best_mag(merge_mag)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (d_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (d_adv) begin
         rsp_idx_ff <= merge_idx;
         rsp_mag_ff <= merge_mag;
         rsp_tag_ff <= d_tag_ff;
         rsp_col_ff <= d_col_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_image    = rsp_idx_ff;
   assign rsp_best_saliency = rsp_mag_ff;
   assign rsp_out_row       = rsp_tag_ff.row;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_in_run   = rsp_tag_ff.last_in_run;
   assign rsp_frame_done    = rsp_tag_ff.frame_done;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         rsp_last_in_run && (rsp_out_row == last_row) && (rsp_out_col == last_col))
      else $error("frame end result not at last pixel");

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !c_free |=> b_valid_ff && $stable(b_pix_ff) && $stable(b_col_ff))
      else $error("read stage item lost while window busy");

   assert property (@(posedge clock) disable iff (reset)
      (c_mask_ff != '0) |-> (c_row_ff != '0) && (c_col_ff != '0))
      else $error("result pending for item in first row or column");

endmodule

[rtl/core/lsa_line_ram.sv]
// single-port line store bank with registered read
module lsa_line_ram #(
   parameter int DEPTH = lsa_pkg::DefaultMaxWidth,
   parameter int WIDTH = lsa_pkg::PackBits
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lsa_lane.sv]
// absolute 3x3 laplacian of one frame's neighbourhood
module lsa_lane (
   input  lsa_pkg::lsa_win_type        win,
   output logic [lsa_pkg::MagBits-1:0] mag
);
   import lsa_pkg::*;

   logic [MagBits-1:0] nsum;
   logic [MagBits:0]   diff;

   always_comb begin
      nsum = '0;
      for (int i = 0; i < 9; i++) begin
         if (i != 4) begin
            nsum = nsum + MagBits'(win[i]);
         end
      end
      diff = {1'b0, nsum} - {1'b0, win[4], 3'b000};
      if (diff[MagBits]) begin
         mag = MagBits'(-diff);
      end else begin
         mag = diff[MagBits-1:0];
      end
   end

endmodule

[rtl/core/lsa_merge.sv]
// picks the frame with the strictly largest magnitude, lower index on ties
module lsa_merge (
   input  lsa_pkg::lsa_mag_array_type  mags,
   output logic [lsa_pkg::ImgBits-1:0] best_idx,
   output logic [lsa_pkg::MagBits-1:0] best_mag
);
   import lsa_pkg::*;

   always_comb begin
      best_idx = '0;
      best_mag = '0;
      for (int k = 0; k < NumImages; k++) begin
         if (mags[k] > best_mag) begin
            best_mag = mags[k];
            best_idx = ImgBits'(k);
         end
      end
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the laplacian saliency selector with its own raster predictor
module testbench;
   import lsa_pkg::*;

   localparam int MaxW         = DefaultMaxWidth;
   localparam int SettleCycles = 24;
   localparam int IdleLimit    = 5000;
   localparam int HoldCycles   = 300;
   localparam int HoldAfter    = 30;
   localparam int RandomItems  = 180;

   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_CSR,
      OP_PAUSE
   } op_kind_type;

   typedef enum logic [1:0] {
      STYLE_NOISE,
      STYLE_EXTREME,
      STYLE_FLAT
   } pix_style_type;

   typedef struct {
      op_kind_type        kind;
      logic [31:0]        pixels;
      lsa_csr_type        index;
      logic [12:0]        data;
   } stream_op_type;

   typedef struct packed {
      logic [ImgBits-1:0] image;
      logic [MagBits-1:0] saliency;
      logic [RowBits-1:0] row;
      logic [9:0]         col;
      logic               last_in_run;
      logic               frame_done;
   } pixel_pick_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PixBits-1:0]      req_gray_0 = '0;
   logic [PixBits-1:0]      req_gray_1 = '0;
   logic [PixBits-1:0]      req_gray_2 = '0;
   logic [PixBits-1:0]      req_gray_3 = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ImgBits-1:0]      rsp_best_image;
   logic [MagBits-1:0]      rsp_best_saliency;
   logic [RowBits-1:0]      rsp_out_row;
   logic [9:0]              rsp_out_col;
   logic                    rsp_last_in_run;
   logic                    rsp_frame_done;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   lsa_csr_type             csr_index = CSR_FRAME_WIDTH;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   stream_op_type  stream_ops[$];
   pixel_pick_type picks_due[$];
   int             errors = 0;

   // predictor state
   logic [31:0] line_mem [2*MaxW];
   logic [31:0] win [3][3];
   int          ras_row;
   int          ras_col;
   int          cfg_width;
   int          cfg_height;

   // driver and monitor state
   int          gap_left;
   int          settle;
   bit          req_calm;
   int          hold_left;
   int          stall_left;
   bit          rsp_calm;
   int          picks_seen;
   bit          long_hold_done;
   int          idle_cycles;

   laplacian_saliency_argmax u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_gray_0        (req_gray_0),
      .req_gray_1        (req_gray_1),
      .req_gray_2        (req_gray_2),
      .req_gray_3        (req_gray_3),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_best_image    (rsp_best_image),
      .rsp_best_saliency (rsp_best_saliency),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_in_run   (rsp_last_in_run),
      .rsp_frame_done    (rsp_frame_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         flag_error($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // frame with the strongest absolute laplacian over the chosen window rows and columns
   function automatic pixel_pick_type sharpest_frame(input int rt, input int rm, input int rb,
                                                     input int cl, input int cm, input int cr,
                                                     input int row, input int col,
                                                     input bit done);
      int             rows [3];
      int             cols [3];
      int             total;
      int             mag;
      int             best;
      pixel_pick_type p;
      rows = '{rt, rm, rb};
      cols = '{cl, cm, cr};
      best = 0;
      p = '0;
      for (int k = 0; k < NumImages; k++) begin
         total = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               total += int'(win[rows[i]][cols[j]][8*k +: 8]);
            end
         end
         total -= 9 * int'(win[rm][cm][8*k +: 8]);
         mag = (total < 0) ? -total : total;
         if (mag > best) begin
            best = mag;
            p.image = ImgBits'(k);
         end
      end
      p.saliency = MagBits'(best);
      p.row = RowBits'(row);
      p.col = 10'(col);
      p.frame_done = done;
      return p;
   endfunction

   task automatic advance_raster(input logic [31:0] px);
      int             w;
      int             h;
      int             r;
      int             c;
      int             cur;
      int             prv;
      int             n;
      int             top;
      int             left;
      bit             last_row;
      bit             last_col;
      pixel_pick_type run [4];
      w = (cfg_width < 2) ? 2 : (cfg_width > MaxW) ? MaxW : cfg_width;
      h = (cfg_height < 2) ? 2 : (cfg_height > MaxHeight) ? MaxHeight : cfg_height;
      r = ras_row;
      c = ras_col;
      cur = (r % 2) * MaxW + c;
      prv = ((r + 1) % 2) * MaxW + c;
      last_row = (r == h - 1);
      last_col = (c == w - 1);
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = line_mem[cur];
      win[1][2] = line_mem[prv];
      win[2][2] = px;
      line_mem[cur] = px;
      if (r >= 1 && c >= 1) begin
         // reflect the missing row or column at the top and left edges
         top = (r == 1) ? 2 : 0;
         left = (c == 1) ? 2 : 0;
         n = 0;
         run[n] = sharpest_frame(top, 1, 2, left, 1, 2, r - 1, c - 1, 1'b0);
         n++;
         if (last_row) begin
            run[n] = sharpest_frame(1, 2, 1, left, 1, 2, r, c - 1, 1'b0);
            n++;
         end
         if (last_col) begin
            run[n] = sharpest_frame(top, 1, 2, 1, 2, 1, r - 1, c, 1'b0);
            n++;
            if (last_row) begin
               run[n] = sharpest_frame(1, 2, 1, 1, 2, 1, r, c, 1'b1);
               n++;
            end
         end
         run[n-1].last_in_run = 1'b1;
         for (int i = 0; i < n; i++) begin
            picks_due.insert(picks_due.size(), run[i]);
         end
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      ras_row = r;
      ras_col = c;
   endtask

   function automatic void apply_setting(input lsa_csr_type idx, input logic [12:0] data);
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_width = int'(data[WidthBits-1:0]);
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = int'(data);
         end
         default: begin
         end
      endcase
      ras_row = 0;
      ras_col = 0;
   endfunction

   function automatic logic [31:0] draw_pixel(input pix_style_type style);
      logic [31:0] px;
      px = '0;
      for (int k = 0; k < NumImages; k++) begin
         case (style)
            STYLE_NOISE:   px[8*k +: 8] = 8'($urandom_range(0, 255));
            STYLE_EXTREME: px[8*k +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default:       px[8*k +: 8] = 8'(100 + $urandom_range(0, 1));
         endcase
      end
      return px;
   endfunction

   task automatic queue_pixel(input logic [31:0] px);
      stream_op_type op;
      op = '{OP_PIXEL, px, CSR_FRAME_WIDTH, 13'd0};
      stream_ops.insert(stream_ops.size(), op);
   endtask

   task automatic queue_csr(input lsa_csr_type idx, input logic [12:0] data);
      stream_op_type op;
      op = '{OP_CSR, 32'd0, idx, data};
      stream_ops.insert(stream_ops.size(), op);
   endtask

   task automatic queue_pause();
      stream_op_type op;
      op = '{OP_PAUSE, 32'd0, CSR_FRAME_WIDTH, 13'd0};
      stream_ops.insert(stream_ops.size(), op);
   endtask

   task automatic queue_run(input int n, input pix_style_type style);
      for (int i = 0; i < n; i++) begin
         queue_pixel(draw_pixel(style));
      end
   endtask

   // driver: pixel items and register writes, one channel at a time
   always @(posedge clock) begin
      stream_op_type op;
      logic          next_req;
      logic          next_csr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         gap_left = 0;
         settle = 0;
         req_calm = 1'b0;
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         ras_row = 0;
         ras_col = 0;
         cfg_width = int'(FrameWidthReset);
         cfg_height = int'(FrameHeightReset);
      end else begin
         if (req_valid && req_ready) begin
            advance_raster({req_gray_3, req_gray_2, req_gray_1, req_gray_0});
         end
         if (csr_valid && csr_ready) begin
            apply_setting(csr_index, csr_wdata);
         end
         if (!(req_valid && !req_ready) && !(csr_valid && !csr_ready)) begin
            next_req = 1'b0;
            next_csr = 1'b0;
            if ($urandom_range(0, 47) == 0) req_calm = !req_calm;
            if (picks_due.size() != 0) settle = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (stream_ops.size() != 0) begin
               case (stream_ops[0].kind)
                  OP_PIXEL: begin
                     op = stream_ops.pop_front();
                     req_gray_0 <= op.pixels[7:0];
                     req_gray_1 <= op.pixels[15:8];
                     req_gray_2 <= op.pixels[23:16];
                     req_gray_3 <= op.pixels[31:24];
                     next_req = 1'b1;
                     gap_left = req_calm ? 0 : draw_gap();
                  end
                  OP_PAUSE: begin
                     if (picks_due.size() == 0) op = stream_ops.pop_front();
                  end
                  default: begin
                     // let items with no result clear the pipeline first
                     if (picks_due.size() == 0) settle++;
                     if (settle > SettleCycles) begin
                        op = stream_ops.pop_front();
                        csr_index <= op.index;
                        csr_wdata <= op.data;
                        next_csr = 1'b1;
                        settle = 0;
                     end
                  end
               endcase
            end
            req_valid <= next_req;
            csr_valid <= next_csr;
         end
      end
   end

   // monitor: result checking and receiver back-pressure
   always @(posedge clock) begin
      pixel_pick_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
         rsp_calm = 1'b0;
         picks_seen = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            picks_seen++;
            if (picks_due.size() == 0) begin
               flag_error($sformatf("unexpected item row %0d col %0d", rsp_out_row, rsp_out_col));
            end else begin
               want = picks_due.pop_front();
               check_field("best_image", int'(rsp_best_image), int'(want.image));
               check_field("best_saliency", int'(rsp_best_saliency), int'(want.saliency));
               check_field("out_row", int'(rsp_out_row), int'(want.row));
               check_field("out_col", int'(rsp_out_col), int'(want.col));
               check_field("last_in_run", int'(rsp_last_in_run), int'(want.last_in_run));
               check_field("frame_done", int'(rsp_frame_done), int'(want.frame_done));
            end
         end
         if (!long_hold_done && picks_seen >= HoldAfter && req_valid) begin
            long_hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if ($urandom_range(0, 47) == 0) rsp_calm = !rsp_calm;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0) stall_left = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("laplacian_saliency_argmax test failed");
            $finish;
         end
      end
   end

   initial begin
      int            queued;
      int            n;
      int            split;
      int            plan_w;
      int            plan_h;
      int            w_val;
      int            h_val;
      bit            centre;
      bit            first;
      logic [12:0]   data;
      pix_style_type style;

      // 3x3 frame: one frame peaks at the centre, another dips there, equal magnitudes
      queue_csr(CSR_FRAME_WIDTH, 13'd3);
      queue_csr(CSR_FRAME_HEIGHT, 13'd3);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            centre = (r == 1 && c == 1);
            queue_pixel({centre ? 8'h00 : 8'hff, 8'(17 * (3 * r + c)), 8'h00,
                         centre ? 8'hff : 8'h00});
         end
      end
      // sizes below the minimum, flat frames then a frame where only frame 3 varies
      queue_csr(CSR_FRAME_WIDTH, 13'd1);
      queue_csr(CSR_FRAME_HEIGHT, 13'd0);
      repeat (4) queue_pixel(32'h55aaff00);
      queue_pixel({8'hff, 24'h123456});
      queue_pixel({8'h00, 24'h123456});
      queue_pixel({8'h00, 24'h123456});
      queue_pixel({8'hff, 24'h123456});
      // sizes above the maximum, abandoned part way through the first row
      queue_csr(CSR_FRAME_WIDTH, 13'h1fff);
      queue_csr(CSR_FRAME_HEIGHT, 13'h1fff);
      queue_run(5, STYLE_EXTREME);
      // mid-size frame with a pause part way through
      queue_csr(CSR_FRAME_WIDTH, 13'd8);
      queue_csr(CSR_FRAME_HEIGHT, 13'd4);
      queue_run(20, STYLE_NOISE);
      queue_pause();
      queue_run(12, STYLE_NOISE);

      queued = 0;
      first = 1'b1;
      plan_w = 2;
      plan_h = 2;
      while (queued < RandomItems) begin
         w_val = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(2, 6);
         h_val = $urandom_range(2, 5);
         if (first || $urandom_range(0, 2) != 0) begin
            data = 13'(w_val);
            if (w_val == 2 && $urandom_range(0, 2) == 0) data = 13'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) data = data | (13'($urandom_range(1, 3)) << 11);
            queue_csr(CSR_FRAME_WIDTH, data);
            plan_w = w_val;
         end
         if (first || $urandom_range(0, 2) != 0) begin
            data = 13'(h_val);
            if (h_val == 2 && $urandom_range(0, 2) == 0) data = 13'($urandom_range(0, 1));
            queue_csr(CSR_FRAME_HEIGHT, data);
            plan_h = h_val;
         end
         first = 1'b0;
         style = pix_style_type'($urandom_range(0, 2));
         if ($urandom_range(0, 9) < 7) begin
            n = plan_w * plan_h * $urandom_range(1, 2);
         end else begin
            n = $urandom_range(1, plan_w * plan_h - 1);
         end
         if (n > RandomItems - queued) n = RandomItems - queued;
         if ($urandom_range(0, 3) == 0) begin
            split = $urandom_range(0, n);
            queue_run(split, style);
            queue_pause();
            queue_run(n - split, style);
         end else begin
            queue_run(n, style);
         end
         queued += n;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (stream_ops.size() != 0 || req_valid || csr_valid || picks_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("laplacian_saliency_argmax test passed");
      end else begin
         $display("laplacian_saliency_argmax test failed");
      end
      $finish;
   end

endmodule

[laplacian_saliency_argmax.f]
rtl/core/lsa_pkg.sv
rtl/core/lsa_line_ram.sv
rtl/core/lsa_lane.sv
rtl/core/lsa_merge.sv
rtl/core/laplacian_saliency_argmax.sv
test/testbench.sv
